/* design/rrkx_pkg.sv */
`default_nettype none
package rrkx_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned RING_LEN = 17;
   localparam int unsigned RING_AW = $clog2(RING_LEN);
   localparam int unsigned CNT_W = RING_AW;

   localparam logic [WORD_W-1:0] SEED_MULT = 32'h53A9_B4FB;
   localparam int unsigned ROT_A = 9;
   localparam int unsigned ROT_B = 13;
   localparam logic [RING_AW-1:0] INDEX_B_START = RING_AW'(10);
   localparam int unsigned WARMUP_STEPS = 9;
   localparam int unsigned BYTE_STEPS = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;       // item accepted this cycle
      logic                 restart;    // accepted item reseeds
      logic                 seed_step;  // write one seed word
      logic [RING_AW-1:0]   seed_idx;
      logic                 gen_step;   // one generator step
      logic                 gen_last;   // this step yields the keystream byte
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;                    // result register holds an unclaimed item
   } dp_sts_type;

   function automatic logic [RING_AW-1:0] idx_dec(input logic [RING_AW-1:0] i);
      logic [RING_AW-1:0] r;
      if (i == '0) begin
         r = RING_AW'(RING_LEN - 1);
      end else begin
         r = i - RING_AW'(1);
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] v,
                                             input int unsigned r);
      logic [WORD_W-1:0] res;
      res = (v << r) | (v >> (WORD_W - r));
      return res;
   endfunction

endpackage
`default_nettype wire

/* design/rrkx_req_if.sv */
`default_nettype none
interface rrkx_req_if import rrkx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_in;
   logic              restart;

   modport source (output valid, output data_in, output restart, input ready);
   modport sink   (input valid, input data_in, input restart, output ready);
endinterface
`default_nettype wire

/* design/rrkx_rsp_if.sv */
`default_nettype none
interface rrkx_rsp_if import rrkx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface
`default_nettype wire

/* design/rrkx_csr_if.sv */
`default_nettype none
interface rrkx_csr_if import rrkx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] seed;

   modport source (output valid, output seed, input ready);
   modport sink   (input valid, input seed, output ready);
endinterface
`default_nettype wire

/* design/rrkx_ram.sv */
`default_nettype none
module rrkx_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 17
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

/* design/rrkx_ctrl.sv */
`default_nettype none
module rrkx_ctrl import rrkx_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_restart,
   output logic            req_ready,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEED = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   localparam logic [CNT_W-1:0] SEED_LAST   = CNT_W'(RING_LEN - 1);
   localparam logic [CNT_W-1:0] RESEED_RUN  = CNT_W'(WARMUP_STEPS + BYTE_STEPS);
   localparam logic [CNT_W-1:0] PLAIN_RUN   = CNT_W'(BYTE_STEPS);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE) && !sts.out_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      cmd              = '0;
      cmd.load         = accept;
      cmd.restart      = req_restart;
      cmd.seed_idx     = cnt_ff[RING_AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  state_in = ST_SEED;
                  cnt_in   = '0;
               end else begin
                  state_in = ST_RUN;
                  cnt_in   = PLAIN_RUN;
               end
            end
         end
         ST_SEED: begin
            cmd.seed_step = 1'b1;
            if (cnt_ff == SEED_LAST) begin
               state_in = ST_RUN;
               cnt_in   = RESEED_RUN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_RUN: begin
            cmd.gen_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               cmd.gen_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* design/rrkx_dp.sv */
`default_nettype none
module rrkx_dp import rrkx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_sts_type             sts,
   input  wire logic [DATA_W-1:0] req_data,
   input  wire logic              csr_we,
   input  wire logic [WORD_W-1:0] csr_seed,
   output logic                   rsp_valid,
   output logic [DATA_W-1:0]      rsp_data,
   input  wire logic              rsp_ready
);

   logic [WORD_W-1:0]   seed_ff;
   logic [WORD_W-1:0]   s_ff, s_in;
   logic [RING_AW-1:0]  a_ff, a_in, b_ff, b_in;
   logic [RING_LEN-1:0] valid_ff;
   logic                vld_a_ff, vld_b_ff;
   logic [DATA_W-1:0]   data_ff;
   logic                out_vld_ff;
   logic [DATA_W-1:0]   out_data_ff;
   logic [RING_AW-1:0]  rd_a, rd_b, wr_addr;
   logic [WORD_W-1:0]   ram_a, ram_b, word_a, word_b, sum, wr_data;
   logic                wr_en;
   logic [WORD_W-1:0]   prod;

   // A step reads the pair it leaves behind, so consecutive steps overlap.
   assign rd_a = cmd.gen_step ? idx_dec(a_ff) : a_ff;
   assign rd_b = cmd.gen_step ? idx_dec(b_ff) : b_ff;

   assign prod = s_ff * SEED_MULT;
   assign s_in = WORD_W'(1) - prod;

   // Ring entries never written since reset read as zero.
   assign word_a = vld_a_ff ? ram_a : '0;
   assign word_b = vld_b_ff ? ram_b : '0;
   assign sum    = rol(word_a, ROT_A) + rol(word_b, ROT_B);

   assign wr_en   = cmd.seed_step || cmd.gen_step;
   assign wr_addr = cmd.seed_step ? cmd.seed_idx : a_ff;
   assign wr_data = cmd.seed_step ? s_in : sum;

   rrkx_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RING_LEN)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_a),
      .rd_addr_b (rd_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (cmd.load && cmd.restart) begin
         a_in = '0;
         b_in = INDEX_B_START;
      end else if (cmd.gen_step) begin
         a_in = idx_dec(a_ff);
         b_in = idx_dec(b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         a_ff       <= '0;
         b_ff       <= INDEX_B_START;
         valid_ff   <= '0;
         vld_a_ff   <= 1'b0;
         vld_b_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            seed_ff <= csr_seed;
         end
         a_ff     <= a_in;
         b_ff     <= b_in;
         vld_a_ff <= valid_ff[rd_a];
         vld_b_ff <= valid_ff[rd_b];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.gen_last) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         data_ff <= req_data;
      end
      if (cmd.load && cmd.restart) begin
         s_ff <= seed_ff;
      end else if (cmd.seed_step) begin
         s_ff <= s_in;
      end
      if (cmd.gen_last) begin
         out_data_ff <= data_ff ^ sum[WORD_W-1 -: DATA_W];
      end
   end

   assign sts.out_busy = out_vld_ff && !rsp_ready;
   assign rsp_valid    = out_vld_ff;
   assign rsp_data     = out_data_ff;

endmodule
`default_nettype wire

/* design/ranrot_keystream_xor_cipher.sv */
`default_nettype none
// Stream XOR cipher whose keystream comes from a rotate-add lagged generator
// over a ring of 17 words held in a RAM with two registered read ports. Each
// item runs two generator steps, one per cycle, and XORs its byte with the
// top byte of the second sum; the next item is taken only once the controller
// is idle again and the result register is free. An item with restart first
// refills the ring from the seed register, one multiply per cycle for each of
// the 17 words, then runs 9 warm-up steps and its own two. The seed register
// may be written at any time and is used at the next restart; the first item
// after reset should set restart, otherwise the ring starts all zero and the
// keystream stays zero until a reseed.
module ranrot_keystream_xor_cipher import rrkx_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   rrkx_req_if.sink   req_ch,
   rrkx_rsp_if.source rsp_ch,
   rrkx_csr_if.sink   csr_ch
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ch.ready = 1'b1;

   rrkx_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_restart (req_ch.restart),
      .req_ready   (req_ch.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   rrkx_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_ch.data_in),
      .csr_we    (csr_ch.valid),
      .csr_seed  (csr_ch.seed),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_ch.data_out),
      .rsp_ready (rsp_ch.ready)
   );

   // Only one operation drives the ring in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.seed_step, cmd.gen_step}))
      else $error("ring operations overlap");

   // The result of the last step is registered and offered next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.gen_last |=> rsp_ch.valid)
      else $error("finished item not offered");

   // A new item is taken only when the result register will be free.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("item accepted with result register occupied");

   // The keystream byte comes only from a generator step.
   assert property (@(posedge clock) disable iff (reset)
      cmd.gen_last |-> cmd.gen_step)
      else $error("result without generator step");

endmodule
`default_nettype wire
